FILE: rtl/gcdc_pkg.sv
// ============================================================================
// Gear chunker package
// Shared constants, register codes, cut reason codes and the gear table
// for the content-defined chunker.
// ============================================================================
package gcdc_pkg;

    // Widths fixed by the register and field definitions.
    localparam int MIN_CHUNK_WIDTH = 20;
    localparam int MAX_CHUNK_WIDTH = 21;
    localparam int MASK_WIDTH      = 20;
    localparam int CFG_DATA_WIDTH  = 21;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int GEAR_WIDTH      = 64;
    localparam int GEAR_DEPTH      = 256;

    // Only the low hash bits can reach the boundary mask, so only those are kept.
    localparam int HASH_WIDTH = MASK_WIDTH;

    // Default geometry parameters.
    localparam int DEF_LENGTH_WIDTH = 21;
    localparam int DEF_OFFSET_WIDTH = 48;

    // Register reset values.
    localparam logic [MIN_CHUNK_WIDTH-1:0] MIN_CHUNK_RESET     = MIN_CHUNK_WIDTH'(8 * 1024);
    localparam logic [MAX_CHUNK_WIDTH-1:0] MAX_CHUNK_RESET     = MAX_CHUNK_WIDTH'(128 * 1024);
    localparam logic [MASK_WIDTH-1:0]      BOUNDARY_MASK_RESET = MASK_WIDTH'(32 * 1024 - 1);

    // Register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_CHUNK     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CHUNK     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOUNDARY_MASK = 2'd2;

    // Cut reason codes.
    typedef enum logic [1:0] {
        REASON_HASH = 2'd0,
        REASON_MAX  = 2'd1,
        REASON_EOS  = 2'd2
    } cut_reason_t;

    // Decision for the byte held in the input register.
    typedef struct packed {
        logic        cut;
        cut_reason_t reason;
        logic        final_chunk;
    } cut_info_t;

    // Generator constants for the gear table.
    localparam logic [63:0] GEAR_SEED = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
    localparam int          GEAR_FOLD = 31;

    typedef logic [GEAR_DEPTH-1:0][GEAR_WIDTH-1:0] gear_rom_t;

    // Builds the gear table at elaboration from a 64-bit LCG sequence.
    function automatic gear_rom_t build_gear_rom();
        gear_rom_t   rom;
        logic [63:0] v;
        v = GEAR_SEED;
        for (int i = 0; i < GEAR_DEPTH; i++) begin
            v = v * LCG_MUL + LCG_ADD;
            rom[i] = v ^ (v >> GEAR_FOLD);
        end
        return rom;
    endfunction

    localparam gear_rom_t GEAR_ROM = build_gear_rom();

endpackage

FILE: rtl/gcdc_in_stage.sv
// ============================================================================
// Gear chunker input stage
// Registers one byte transfer and holds it until the cut core consumes it.
// ============================================================================
module gcdc_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       consume,
    output logic       in_valid,
    output logic [7:0] in_data,
    output logic       in_last
);
    import gcdc_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;

    // The register takes a new byte whenever it is empty or being drained.
    assign s_ready = !valid_reg || consume;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;
    assign in_last  = last_reg;

endmodule

FILE: rtl/gcdc_cut_core.sv
// ============================================================================
// Gear chunker cut core
// Holds the configuration and chunk state, updates the gear hash and
// decides the cut for the byte in the input register.
// ============================================================================
module gcdc_cut_core #(
    parameter int LENGTH_WIDTH = gcdc_pkg::DEF_LENGTH_WIDTH,
    parameter int OFFSET_WIDTH = gcdc_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [gcdc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [gcdc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 in_valid,
    input  logic [7:0]                           in_data,
    input  logic                                 in_last,
    input  logic                                 out_free,
    output logic                                 consume,
    output gcdc_pkg::cut_info_t                  cut_info,
    output logic [OFFSET_WIDTH-1:0]              cut_start,
    output logic [LENGTH_WIDTH-1:0]              cut_length
);
    import gcdc_pkg::*;

    // Compare width that covers both the length counter and the registers.
    localparam int CMP_WIDTH = (LENGTH_WIDTH > MAX_CHUNK_WIDTH) ? LENGTH_WIDTH
                                                                : MAX_CHUNK_WIDTH;

    logic [MIN_CHUNK_WIDTH-1:0] min_chunk_reg;
    logic [MAX_CHUNK_WIDTH-1:0] max_chunk_reg;
    logic [MASK_WIDTH-1:0]      boundary_mask_reg;

    logic [HASH_WIDTH-1:0]   hash_reg, hash_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;

    logic [HASH_WIDTH-1:0]   hash_upd;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    hashing;
    logic                    hash_cut;
    logic                    max_cut;
    cut_info_t               info;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_chunk_reg     <= MIN_CHUNK_RESET;
            max_chunk_reg     <= MAX_CHUNK_RESET;
            boundary_mask_reg <= BOUNDARY_MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_CHUNK:     min_chunk_reg     <= cfg_wdata[MIN_CHUNK_WIDTH-1:0];
                CFG_MAX_CHUNK:     max_chunk_reg     <= cfg_wdata[MAX_CHUNK_WIDTH-1:0];
                CFG_BOUNDARY_MASK: boundary_mask_reg <= cfg_wdata[MASK_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Gear hash step: shift left by one and add the table entry.
    assign hashing  = CMP_WIDTH'(count_reg) >= CMP_WIDTH'(min_chunk_reg);
    assign hash_upd = {hash_reg[HASH_WIDTH-2:0], 1'b0}
                    + GEAR_ROM[in_data][HASH_WIDTH-1:0];
    assign hash_cut = hashing && ((hash_upd & boundary_mask_reg) == '0);

    // Length checks against the register and the counter's own ceiling.
    assign len     = count_reg + LENGTH_WIDTH'(1);
    assign max_cut = (CMP_WIDTH'(len) == CMP_WIDTH'(max_chunk_reg)) || (&len);

    // Reason priority: hash boundary, then maximum length, then end of stream.
    always_comb begin
        info.final_chunk = in_last;
        info.cut         = 1'b1;
        if (hash_cut) begin
            info.reason = REASON_HASH;
        end else if (max_cut) begin
            info.reason = REASON_MAX;
        end else begin
            info.reason = REASON_EOS;
            info.cut    = in_last;
        end
    end

    // A byte that cuts needs a free result register; others pass at once.
    assign consume = in_valid && (!info.cut || out_free);

    // State update for a consumed byte.
    always_comb begin
        hash_next  = hash_reg;
        count_next = count_reg;
        start_next = start_reg;
        if (consume) begin
            if (!info.cut) begin
                if (hashing) begin
                    hash_next = hash_upd;
                end
                count_next = len;
            end else begin
                hash_next  = '0;
                count_next = '0;
                if (in_last) begin
                    start_next = '0;
                end else begin
                    start_next = start_reg + OFFSET_WIDTH'(len);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= '0;
            count_reg <= '0;
            start_reg <= '0;
        end else begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

    assign cut_info   = info;
    assign cut_start  = start_reg;
    assign cut_length = len;

endmodule

FILE: rtl/gcdc_out_stage.sv
// ============================================================================
// Gear chunker output stage
// Result register that holds one chunk record until it is taken.
// ============================================================================
module gcdc_out_stage #(
    parameter int LENGTH_WIDTH = gcdc_pkg::DEF_LENGTH_WIDTH,
    parameter int OFFSET_WIDTH = gcdc_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  gcdc_pkg::cut_info_t         cut_info,
    input  logic [OFFSET_WIDTH-1:0]     cut_start,
    input  logic [LENGTH_WIDTH-1:0]     cut_length,
    output logic                        out_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [OFFSET_WIDTH-1:0]     m_chunk_start,
    output logic [LENGTH_WIDTH-1:0]     m_chunk_length,
    output logic [1:0]                  m_cut_reason,
    output logic                        m_final_chunk
);
    import gcdc_pkg::*;

    logic                    valid_reg, valid_next;
    logic [OFFSET_WIDTH-1:0] start_reg;
    logic [LENGTH_WIDTH-1:0] length_reg;
    cut_reason_t             reason_reg;
    logic                    final_reg;

    // Free when empty or when the held record transfers this cycle.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            start_reg  <= cut_start;
            length_reg <= cut_length;
            reason_reg <= cut_info.reason;
            final_reg  <= cut_info.final_chunk;
        end
    end

    assign m_valid        = valid_reg;
    assign m_chunk_start  = start_reg;
    assign m_chunk_length = length_reg;
    assign m_cut_reason   = reason_reg;
    assign m_final_chunk  = final_reg;

endmodule

FILE: rtl/gear_content_defined_chunker_top.sv
// ============================================================================
// Gear content-defined chunker
// Cuts a byte stream into chunks at gear hash boundaries, at a maximum
// length or at end of stream, and reports one record per closed chunk.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_data_byte, s_last_byte
//  m_        out        m_valid/m_ready    m_chunk_start, m_chunk_length,
//                                          m_cut_reason, m_final_chunk
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
//  One byte per cycle sustained while no cutting byte waits. A byte is
//  registered on transfer, then the hash step and cut decision run on the
//  held byte and a cut loads the result register.
//  Reset (aresetn low, synchronous) restores register defaults and clears
//  the hash, byte count and stream offset.
//  A cutting byte waits in the input register while the result register
//  is full and not being taken; bytes that do not cut never wait.
//
module gear_content_defined_chunker_top #(
    parameter int LENGTH_WIDTH = gcdc_pkg::DEF_LENGTH_WIDTH,
    parameter int OFFSET_WIDTH = gcdc_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [gcdc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [gcdc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [OFFSET_WIDTH-1:0]              m_chunk_start,
    output logic [LENGTH_WIDTH-1:0]              m_chunk_length,
    output logic [1:0]                           m_cut_reason,
    output logic                                 m_final_chunk
);
    import gcdc_pkg::*;

    logic                    in_valid;
    logic [7:0]              in_data;
    logic                    in_last;
    logic                    consume;
    logic                    out_free;
    cut_info_t               cut_info;
    logic [OFFSET_WIDTH-1:0] cut_start;
    logic [LENGTH_WIDTH-1:0] cut_length;

    // Input register.
    gcdc_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .consume     (consume),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .in_last     (in_last)
    );

    // Hash, length tracking and cut decision.
    gcdc_cut_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_cut_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_last    (in_last),
        .out_free   (out_free),
        .consume    (consume),
        .cut_info   (cut_info),
        .cut_start  (cut_start),
        .cut_length (cut_length)
    );

    // Result register.
    gcdc_out_stage #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (consume && cut_info.cut),
        .cut_info       (cut_info),
        .cut_start      (cut_start),
        .cut_length     (cut_length),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_start  (m_chunk_start),
        .m_chunk_length (m_chunk_length),
        .m_cut_reason   (m_cut_reason),
        .m_final_chunk  (m_final_chunk)
    );

    // A closed chunk always holds at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chunk_length != '0))
        else $error("chunk record with zero length");

    // An end-of-stream cut is only reported for the last byte of a stream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cut_reason == REASON_EOS)) |-> m_final_chunk)
        else $error("end-of-stream cut without final flag");

    // A cutting byte is only consumed when the result register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && cut_info.cut) |-> out_free)
        else $error("result register overwritten");

    // A held byte that is not consumed stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !consume) |=> (in_valid && $stable(in_data) && $stable(in_last)))
        else $error("input register lost a byte");

endmodule

FILE: tb/chunk_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Chunk record checker
// Watches the configuration port and both streaming channels of the gear
// chunker. It keeps its own gear hash, chunk fill and stream offset. From
// each accepted byte it works out the chunk record the block must emit and
// compares emitted records, field by field, in order.
// ============================================================================
module chunk_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [gcdc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [gcdc_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [7:0]                              s_data_byte,
    input  logic                                    s_last_byte,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [gcdc_pkg::DEF_OFFSET_WIDTH-1:0]   m_chunk_start,
    input  logic [gcdc_pkg::DEF_LENGTH_WIDTH-1:0]   m_chunk_length,
    input  logic [1:0]                              m_cut_reason,
    input  logic                                    m_final_chunk,
    output int                                      failures,
    output int                                      due_count
);
    import gcdc_pkg::*;

    localparam int LW = DEF_LENGTH_WIDTH;
    localparam int OW = DEF_OFFSET_WIDTH;

    // Forced cut once a chunk fills the whole length field.
    localparam int unsigned FULL_LENGTH = (1 << LW) - 1;

    // Gear table generator: a 64-bit LCG, each state folded onto itself.
    localparam logic [63:0] LCG_START = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC   = 64'd1442695040888963407;
    localparam int          LCG_FOLD  = 31;

    // Register values after reset.
    localparam logic [19:0] MIN_DEFAULT  = 20'd8192;
    localparam logic [20:0] MAX_DEFAULT  = 21'd131072;
    localparam logic [19:0] MASK_DEFAULT = 20'd32767;

    typedef struct packed {
        logic [OW-1:0] start_off;
        logic [LW-1:0] length;
        cut_reason_t   reason;
        logic          ends_stream;
    } chunk_rec_t;

    logic [63:0]   gear_lut [GEAR_DEPTH];
    logic [19:0]   min_chunk;
    logic [20:0]   max_chunk;
    logic [19:0]   boundary_mask;
    logic [63:0]   gear_hash;
    logic [LW-1:0] chunk_fill;
    logic [OW-1:0] chunk_base;
    chunk_rec_t    chunks_due [$];
    int            errors = 0;

    initial begin : fill_gear_lut
        logic [63:0] v;
        v = LCG_START;
        for (int i = 0; i < GEAR_DEPTH; i++) begin
            v = v * LCG_MULT + LCG_INC;
            gear_lut[i] = v ^ (v >> LCG_FOLD);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: chunk %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : track
        chunk_rec_t    due;
        logic [LW-1:0] pos;
        logic [LW:0]   len;
        logic          cut;
        cut_reason_t   why;

        if (!aresetn) begin
            min_chunk     = MIN_DEFAULT;
            max_chunk     = MAX_DEFAULT;
            boundary_mask = MASK_DEFAULT;
            gear_hash     = '0;
            chunk_fill    = '0;
            chunk_base    = '0;
            chunks_due.delete();
        end else begin
            // A record leaving the block is matched against the oldest one due.
            if (m_valid && m_ready) begin
                if (chunks_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected chunk: start 0x%0h length %0d reason %0d",
                             $time, m_chunk_start, m_chunk_length, m_cut_reason);
                end else begin
                    due = chunks_due.pop_front();
                    check_field("start", due.start_off, m_chunk_start);
                    check_field("length", due.length, m_chunk_length);
                    check_field("reason", due.reason, m_cut_reason);
                    check_field("final", due.ends_stream, m_final_chunk);
                end
            end

            // Register writes are cut to the register width; other indexes do nothing.
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_CHUNK:     min_chunk = cfg_wdata[19:0];
                    CFG_MAX_CHUNK:     max_chunk = cfg_wdata[20:0];
                    CFG_BOUNDARY_MASK: boundary_mask = cfg_wdata[19:0];
                    default: ;
                endcase
            end

            // Each accepted byte advances the chunker by one position.
            if (s_valid && s_ready) begin
                pos = chunk_fill;
                cut = 1'b0;
                why = REASON_HASH;
                if (pos >= min_chunk) begin
                    gear_hash = (gear_hash << 1) + gear_lut[s_data_byte];
                    if ((gear_hash[19:0] & boundary_mask) == '0)
                        cut = 1'b1;
                end
                len = pos + 1'b1;
                if (!cut && (len == max_chunk || len >= FULL_LENGTH)) begin
                    cut = 1'b1;
                    why = REASON_MAX;
                end
                if (!cut && s_last_byte) begin
                    cut = 1'b1;
                    why = REASON_EOS;
                end

                if (!cut) begin
                    chunk_fill = len[LW-1:0];
                end else begin
                    due = '{chunk_base, len[LW-1:0], why, s_last_byte};
                    chunks_due.insert(chunks_due.size(), due);
                    // A final chunk restarts the stream at offset zero.
                    chunk_base = s_last_byte ? '0 : chunk_base + len;
                    chunk_fill = '0;
                    gear_hash  = '0;
                end
            end
        end
        due_count <= chunks_due.size();
        failures  <= errors;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Gear chunker testbench
// Drives byte streams into the chunker under a series of register settings:
// a short directed part for the corner cases, then random streams with
// random flow control on both channels. The chunk checker predicts and
// compares every record; this module gives the verdict.
// ============================================================================
module tb;
    import gcdc_pkg::*;

    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 129;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          LONG_HOLD       = 400;
    localparam int          STALL_LIMIT     = 2000;
    localparam int unsigned MIN_TOP         = 1048575;
    localparam int unsigned MAX_TOP         = 1048576;
    localparam int unsigned MASK_TOP        = 1048575;

    // Index that no register answers to.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index     = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_wdata     = '0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_data_byte   = '0;
    logic                        s_last_byte   = 1'b0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [DEF_OFFSET_WIDTH-1:0] m_chunk_start;
    logic [DEF_LENGTH_WIDTH-1:0] m_chunk_length;
    logic [1:0]                  m_cut_reason;
    logic                        m_final_chunk;

    int failures;
    int due_count;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    gear_content_defined_chunker_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_start  (m_chunk_start),
        .m_chunk_length (m_chunk_length),
        .m_cut_reason   (m_cut_reason),
        .m_final_chunk  (m_final_chunk)
    );

    chunk_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_start  (m_chunk_start),
        .m_chunk_length (m_chunk_length),
        .m_cut_reason   (m_cut_reason),
        .m_final_chunk  (m_final_chunk),
        .failures       (failures),
        .due_count      (due_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offers one byte and holds it until the transfer, then maybe idles.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every chunk record due has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Writes all three registers, plus a write to the unused index.
    task automatic set_config(input int unsigned min_v, input int unsigned max_v,
                              input int unsigned mask_v);
        write_reg(CFG_MIN_CHUNK, CFG_DATA_WIDTH'(min_v));
        write_reg(CFG_MAX_CHUNK, CFG_DATA_WIDTH'(max_v));
        write_reg(CFG_BOUNDARY_MASK, CFG_DATA_WIDTH'(mask_v));
        write_reg(CFG_UNUSED, CFG_DATA_WIDTH'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // Result side: random ready with one long hold-off when asked for.
    initial begin : result_sink
        int stretch;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 8);
            // A pending hold-off request cuts the ready stretch short.
            for (int k = 0; k < stretch && !(hold_request && !hold_done); k++)
                @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned min_v;
        int unsigned max_v;
        int unsigned mask_v;
        int          last_odds;
        logic [7:0]  value;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers: short streams end before any hashing.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        wait_idle();

        // Zero mask and zero max length; the top data bit must be dropped from
        // the minimum. Every byte cuts on the hash, even the one ending the stream.
        set_config(32'h0010_0000, 0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_idle();

        // Max length equal to the minimum: forced and end-of-stream cuts only, and a forced cut
        // wins over the end of stream.
        set_config(2, 2, MASK_TOP);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h40, 1'b1);
        wait_idle();

        // Largest minimum and mask, with a max length of 2^20.
        set_config(MIN_TOP, MAX_TOP, MASK_TOP);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_idle();

        // Max length one: every byte is a chunk of its own.
        set_config(0, 1, MASK_TOP);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        wait_idle();

        // Random streams, one register setting per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                // Frequent cuts and no sender gaps while the result side holds off.
                min_v  = 0;
                max_v  = 4;
                mask_v = 3;
                calm   = 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0:       min_v = 0;
                    1:       min_v = $urandom_range(1, 8);
                    2:       min_v = $urandom_range(9, 48);
                    default: min_v = $urandom_range(0, 1) ? MIN_TOP : $urandom_range(0, 200);
                endcase
                case ($urandom_range(0, 4))
                    0:       max_v = 0;
                    1:       max_v = $urandom_range(1, 64);
                    2:       max_v = (min_v + 32 > MAX_TOP) ? MAX_TOP
                                     : min_v + $urandom_range(1, 32);
                    3:       max_v = $urandom_range(1, min_v + 1);
                    default: max_v = MAX_TOP;
                endcase
                case ($urandom_range(0, 4))
                    0:       mask_v = 0;
                    1, 2:    mask_v = $urandom_range(1, 31);
                    3:       mask_v = $urandom_range(32, 1023);
                    default: mask_v = $urandom_range(0, 1) ? MASK_TOP : ($urandom() & MASK_TOP);
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            set_config(min_v, max_v, mask_v);
            last_odds = $urandom_range(3, 64);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 10)
                    hold_request = 1'b1;
                case ($urandom_range(0, 9))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    default: value = $urandom_range(0, 255);
                endcase
                send_byte(value, $urandom_range(1, last_odds) == 1);
                if ($urandom_range(0, 149) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        if (failures == 0 && due_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
